>>> rtl/core/lbp_pkg.sv
package lbp_pkg;

   // configuration register map
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_reg_type;

   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET = 11'd480;

   // frame geometry
   localparam int                    ROW_W     = 10;
   localparam int                    COORD_W   = 10;
   localparam logic [CSR_DATA_W-1:0] DIM_MIN   = 11'd3;
   localparam logic [CSR_DATA_W-1:0] ROW_LIMIT = 11'd1024;

   // code bit positions, clockwise from top-left
   localparam int CODE_W    = 8;
   localparam int BIT_TL    = 7;
   localparam int BIT_TOP   = 6;
   localparam int BIT_TR    = 5;
   localparam int BIT_RIGHT = 4;
   localparam int BIT_BR    = 3;
   localparam int BIT_BOT   = 2;
   localparam int BIT_BL    = 1;
   localparam int BIT_LEFT  = 0;

   // one result as it sits in the output queue
   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [COORD_W-1:0] center_col;
      logic [COORD_W-1:0] center_row;
      logic               last;
   } result_type;

endpackage

>>> rtl/core/lbp_stream_if.sv
// pixel channel
interface lbp_req_if #(
   parameter int PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel;
   logic                  frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// code channel
interface lbp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lbp_pkg::CODE_W-1:0]    code;
   logic [lbp_pkg::COORD_W-1:0]   center_col;
   logic [lbp_pkg::COORD_W-1:0]   center_row;
   logic                          last;

   modport source (output valid, output code, output center_col, output center_row,
                   output last, input ready);
   modport sink   (input valid, input code, input center_col, input center_row,
                   input last, output ready);
endinterface

>>> rtl/core/lbp_texture_code_stream_core.sv
// 3x3 local binary pattern over a raster-order pixel stream. The block takes one
// pixel per clock while the output queue has room and produces one 8-bit code
// per interior pixel, together with its column and row, once the pixel
// below-right of it has arrived; border pixels give no transfer. A pixel passes
// through two stages: the first updates the position counters and reads both
// line buffers at the current column, the second compares the neighborhood,
// shifts the 3x3 window and writes the line buffers back. The sustained rate is
// one pixel per cycle, set by the one read and one write per cycle on each line
// buffer, as long as the result side keeps taking codes; a three-entry output
// queue absorbs short stalls before the pixel side is held. Frame size comes
// from the width and height registers (clamped to 3..MAX_WIDTH and 3..1024);
// frame_start forces the current pixel to position (0,0), and last marks the
// final interior code of a frame. Registers are to be written only while no
// pixel is in flight; the user must see to it, as the block does not enforce it.
module lbp_texture_code_stream_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   lbp_req_if.sink                          req_ch,
   lbp_rsp_if.source                        rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [lbp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int DIM_W   = (COL_W + 1 > lbp_pkg::CSR_DATA_W) ? COL_W + 1
                                                             : lbp_pkg::CSR_DATA_W;
   localparam int Q_DEPTH = 3;
   localparam int QPTR_W  = 2;
   localparam int QCNT_W  = 2;

   // ---------------------------------------------------------------------------
   // configuration
   logic [lbp_pkg::CSR_DATA_W-1:0] img_w_ff, img_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= lbp_pkg::WIDTH_RESET;
         img_h_ff <= lbp_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (lbp_pkg::csr_reg_type'(csr_index))
            lbp_pkg::REG_IMAGE_WIDTH:  img_w_ff <= csr_wdata;
            lbp_pkg::REG_IMAGE_HEIGHT: img_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped frame size, as last column and last row
   logic [DIM_W-1:0]               w_ext, w_clamp, w_last;
   logic [lbp_pkg::CSR_DATA_W-1:0] h_clamp;
   logic [lbp_pkg::ROW_W-1:0]      h_last;

   always_comb begin
      w_ext = DIM_W'(img_w_ff);
      if (w_ext < DIM_W'(lbp_pkg::DIM_MIN))
         w_clamp = DIM_W'(lbp_pkg::DIM_MIN);
      else if (w_ext > DIM_W'(MAX_WIDTH))
         w_clamp = DIM_W'(MAX_WIDTH);
      else
         w_clamp = w_ext;
      w_last = w_clamp - DIM_W'(1);

      if (img_h_ff < lbp_pkg::DIM_MIN)
         h_clamp = lbp_pkg::DIM_MIN;
      else if (img_h_ff > lbp_pkg::ROW_LIMIT)
         h_clamp = lbp_pkg::ROW_LIMIT;
      else
         h_clamp = img_h_ff;
      h_last = lbp_pkg::ROW_W'(h_clamp - lbp_pkg::CSR_DATA_W'(1));
   end

   // ---------------------------------------------------------------------------
   // stage 0: position and line buffer read
   logic [COL_W-1:0]          col_ff, col_in;
   logic [lbp_pkg::ROW_W-1:0] row_ff, row_in;
   logic                      req_xfer;
   logic [COL_W-1:0]          s0_col;
   logic [lbp_pkg::ROW_W-1:0] s0_row;
   logic                      s0_emit, s0_last, s0_byp;
   logic                      row_end;

   logic                      s1_valid_ff;
   logic [COL_W-1:0]          s1_col_ff;
   logic [PIXEL_BITS-1:0]     s1_pixel_ff;
   logic                      s1_emit_ff, s1_last_ff, s1_byp_ff;
   logic [lbp_pkg::COORD_W-1:0] s1_ctr_col_ff, s1_ctr_row_ff;
   logic [PIXEL_BITS-1:0]     s1_byp_top_ff, s1_byp_mid_ff;
   logic [PIXEL_BITS-1:0]     top_rd_ff, mid_rd_ff;
   logic [PIXEL_BITS-1:0]     s1_top, s1_mid;

   logic [QCNT_W-1:0]         q_count_ff;
   logic [QCNT_W:0]           q_load;

   assign q_load       = {1'b0, q_count_ff} + {{QCNT_W{1'b0}}, s1_valid_ff};
   assign req_ch.ready = (q_load < (QCNT_W + 1)'(Q_DEPTH));
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      s0_col  = req_ch.frame_start ? '0 : col_ff;
      s0_row  = req_ch.frame_start ? '0 : row_ff;
      row_end = (DIM_W'(s0_col) >= w_last);
      s0_emit = (s0_row >= lbp_pkg::ROW_W'(2)) && (s0_col >= COL_W'(2));
      s0_last = (s0_row == h_last) && (DIM_W'(s0_col) == w_last);
      // the line entry read now is still being written by the item in stage 1
      s0_byp  = s1_valid_ff && (s1_col_ff == s0_col);

      col_in = col_ff;
      row_in = row_ff;
      if (req_xfer) begin
         if (row_end) begin
            col_in = '0;
            row_in = (s0_row >= h_last) ? '0 : s0_row + lbp_pkg::ROW_W'(1);
         end else begin
            col_in = s0_col + COL_W'(1);
            row_in = s0_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line buffers: read in stage 0, written back in stage 1
   logic [PIXEL_BITS-1:0] line_above_mem     [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] line_two_above_mem [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         top_rd_ff <= line_two_above_mem[s0_col];
         mid_rd_ff <= line_above_mem[s0_col];
      end
      if (s1_valid_ff) begin
         line_two_above_mem[s1_col_ff] <= s1_mid;
         line_above_mem[s1_col_ff]     <= s1_pixel_ff;
      end
   end

   // stage 1 pipeline register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_xfer;
      end
      if (req_xfer) begin
         s1_col_ff     <= s0_col;
         s1_pixel_ff   <= req_ch.pixel;
         s1_emit_ff    <= s0_emit;
         s1_last_ff    <= s0_last;
         s1_ctr_col_ff <= lbp_pkg::COORD_W'(s0_col - COL_W'(1));
         s1_ctr_row_ff <= lbp_pkg::COORD_W'(s0_row - lbp_pkg::ROW_W'(1));
         s1_byp_ff     <= s0_byp;
         s1_byp_top_ff <= s1_mid;
         s1_byp_mid_ff <= s1_pixel_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 1: compare, window shift, write-back
   assign s1_top = s1_byp_ff ? s1_byp_top_ff : top_rd_ff;
   assign s1_mid = s1_byp_ff ? s1_byp_mid_ff : mid_rd_ff;

   // window: [0..2] column c-2 (top, mid, bottom), [3..5] column c-1
   logic [PIXEL_BITS-1:0]      win_ff [6];
   logic [lbp_pkg::CODE_W-1:0] s1_code;
   logic [PIXEL_BITS-1:0]      ctr;

   always_comb begin
      ctr = win_ff[4];
      s1_code = '0;
      s1_code[lbp_pkg::BIT_TL]    = (win_ff[0] >= ctr);
      s1_code[lbp_pkg::BIT_TOP]   = (win_ff[3] >= ctr);
      s1_code[lbp_pkg::BIT_TR]    = (s1_top >= ctr);
      s1_code[lbp_pkg::BIT_RIGHT] = (s1_mid >= ctr);
      s1_code[lbp_pkg::BIT_BR]    = (s1_pixel_ff >= ctr);
      s1_code[lbp_pkg::BIT_BOT]   = (win_ff[5] >= ctr);
      s1_code[lbp_pkg::BIT_BL]    = (win_ff[2] >= ctr);
      s1_code[lbp_pkg::BIT_LEFT]  = (win_ff[1] >= ctr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= s1_top;
         win_ff[4] <= s1_mid;
         win_ff[5] <= s1_pixel_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // output queue
   lbp_pkg::result_type q_mem [Q_DEPTH];
   lbp_pkg::result_type q_head;
   logic [QPTR_W-1:0]   q_wr_ff, q_rd_ff;
   logic                q_push, q_pop;

   assign q_push = s1_valid_ff && s1_emit_ff;
   assign q_pop  = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem[q_wr_ff] <= '{code:       s1_code,
                             center_col: s1_ctr_col_ff,
                             center_row: s1_ctr_row_ff,
                             last:       s1_last_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff    <= '0;
         q_rd_ff    <= '0;
         q_count_ff <= '0;
      end else begin
         if (q_push)
            q_wr_ff <= (q_wr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : q_wr_ff + QPTR_W'(1);
         if (q_pop)
            q_rd_ff <= (q_rd_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : q_rd_ff + QPTR_W'(1);
         q_count_ff <= q_count_ff + QCNT_W'(q_push) - QCNT_W'(q_pop);
      end
   end

   assign q_head            = q_mem[q_rd_ff];
   assign rsp_ch.valid      = (q_count_ff != '0);
   assign rsp_ch.code       = q_head.code;
   assign rsp_ch.center_col = q_head.center_col;
   assign rsp_ch.center_row = q_head.center_row;
   assign rsp_ch.last       = q_head.last;

`ifndef ASSERT_OFF
   // the queue never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= QCNT_W'(Q_DEPTH))
      else $error("output queue overflow");

   // a push into a full queue only happens together with a pop
   assert property (@(posedge clock) disable iff (reset)
      (q_push && (q_count_ff == QCNT_W'(Q_DEPTH))) |-> q_pop)
      else $error("result pushed into full queue");

   // back-to-back hit on the same line entry selects the forwarded data
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && s1_valid_ff && (s1_col_ff == s0_col)) |=> s1_byp_ff)
      else $error("line buffer forwarding missed");

   // no result lies on the top row or the left column
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.center_col != '0) && (rsp_ch.center_row != '0)))
      else $error("border pixel emitted");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int CLK_PERIOD     = 4;
   localparam int FRAME_MAX      = 1024;
   localparam int PIX_W          = 8;
   localparam int RANDOM_PIXELS  = 1500;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 200;

   typedef enum int {PIX_UNIFORM, PIX_NEAR_TIES, PIX_EXTREMES} pixel_style_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [lbp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [lbp_pkg::CSR_DATA_W-1:0] csr_wdata;

   lbp_req_if #(.PIXEL_BITS(PIX_W)) req_ch ();
   lbp_rsp_if                       rsp_ch ();

   lbp_texture_code_stream_core #(
      .MAX_WIDTH  (FRAME_MAX),
      .PIXEL_BITS (PIX_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block: registers, line buffers, window, position
   logic [lbp_pkg::CSR_DATA_W-1:0] img_width;
   logic [lbp_pkg::CSR_DATA_W-1:0] img_height;
   logic [PIX_W-1:0]      line_up1 [FRAME_MAX];
   logic [PIX_W-1:0]      line_up2 [FRAME_MAX];
   // line entries that hold a real pixel
   bit                    line_up1_set [FRAME_MAX];
   bit                    line_up2_set [FRAME_MAX];
   logic [PIX_W-1:0]      nbhd [6];
   int unsigned           pos_col;
   int unsigned           pos_row;
   lbp_pkg::result_type   pending_codes [$];

   int unsigned mismatch_count;
   int unsigned pixels_sent;
   int unsigned stall_count;
   int unsigned rsp_hold_req;
   int unsigned tie_base;
   bit          need_sync;
   bit          req_gaps_on;
   bit          rsp_stalls_on;

   // clock
   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned size_clamp(logic [lbp_pkg::CSR_DATA_W-1:0] v);
      if (v < lbp_pkg::DIM_MIN) return lbp_pkg::DIM_MIN;
      if (v > FRAME_MAX) return FRAME_MAX;
      return v;
   endfunction

   // one pixel into the shadow; queues the code it completes, if any
   function automatic void lbp_window_step(logic [PIX_W-1:0] pix, logic fs);
      int unsigned         w, h, c, r;
      logic [PIX_W-1:0]    top, mid, ctr;
      lbp_pkg::result_type res;
      w = size_clamp(img_width);
      h = size_clamp(img_height);
      if (fs) begin
         pos_col = 0;
         pos_row = 0;
      end
      c   = pos_col;
      r   = pos_row;
      top = line_up2[c];
      mid = line_up1[c];
      // nbhd[0..2]: column c-2 top/mid/bottom, nbhd[3..5]: column c-1
      if (r >= 2 && c >= 2) begin
         ctr = nbhd[4];
         res.code                     = '0;
         res.code[lbp_pkg::BIT_TL]    = (nbhd[0] >= ctr);
         res.code[lbp_pkg::BIT_TOP]   = (nbhd[3] >= ctr);
         res.code[lbp_pkg::BIT_TR]    = (top >= ctr);
         res.code[lbp_pkg::BIT_RIGHT] = (mid >= ctr);
         res.code[lbp_pkg::BIT_BR]    = (pix >= ctr);
         res.code[lbp_pkg::BIT_BOT]   = (nbhd[5] >= ctr);
         res.code[lbp_pkg::BIT_BL]    = (nbhd[2] >= ctr);
         res.code[lbp_pkg::BIT_LEFT]  = (nbhd[1] >= ctr);
         res.center_col      = lbp_pkg::COORD_W'(c - 1);
         res.center_row      = lbp_pkg::COORD_W'(r - 1);
         res.last            = (r == h - 1) && (c == w - 1);
         pending_codes.insert(pending_codes.size(), res);
      end
      nbhd[0] = nbhd[3];
      nbhd[1] = nbhd[4];
      nbhd[2] = nbhd[5];
      nbhd[3] = top;
      nbhd[4] = mid;
      nbhd[5] = pix;
      line_up2[c]     = mid;
      line_up1[c]     = pix;
      line_up2_set[c] = line_up1_set[c];
      line_up1_set[c] = 1'b1;
      if (c >= w - 1) begin
         pos_col = 0;
         pos_row = (r >= h - 1) ? 0 : r + 1;
      end else begin
         pos_col = c + 1;
      end
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_len();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) return $urandom_range(3, 1);
      if (pick < 95) return $urandom_range(10, 4);
      return $urandom_range(40, 11);
   endfunction

   function automatic logic [PIX_W-1:0] next_pixel(pixel_style_type style);
      case (style)
         PIX_NEAR_TIES: return PIX_W'(tie_base + $urandom_range(2));
         PIX_EXTREMES:  return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         default:       return PIX_W'($urandom_range(255));
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic write_reg(lbp_pkg::csr_reg_type idx,
                            logic [lbp_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == lbp_pkg::REG_IMAGE_WIDTH) img_width = val;
      else img_height = val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // offer one pixel and wait for its transfer
   task automatic put_pixel(logic [PIX_W-1:0] pix, logic fs);
      int unsigned gap;
      logic        fs_eff;
      fs_eff    = fs | need_sync;
      need_sync = 1'b0;
      gap       = 0;
      if (req_gaps_on && $urandom_range(99) < 20) gap = idle_len();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.pixel       <= pix;
      req_ch.frame_start <= fs_eff;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      lbp_window_step(pix, fs_eff);
      pixels_sent++;
   endtask

   task automatic stop_pixels();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // wait for every queued code, then let the pipeline settle
   task automatic drain_codes();
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // first pixel carries first_fs; noisy runs scatter stray frame starts
   task automatic send_run(int unsigned count, logic first_fs, pixel_style_type style,
                           bit noisy);
      logic fs;
      for (int unsigned i = 0; i < count; i++) begin
         fs = (i == 0) ? first_fs : (noisy && $urandom_range(19) == 0);
         put_pixel(next_pixel(style), fs);
      end
   endtask

   // smallest frame, mixed code with a tie on the top neighbor
   task automatic test_smallest_frame();
      logic [PIX_W-1:0] px [9] = '{255, 100, 99, 0, 100, 101, 100, 255, 0};
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      write_reg(lbp_pkg::REG_IMAGE_WIDTH, 11'd3);
      write_reg(lbp_pkg::REG_IMAGE_HEIGHT, 11'd3);
      foreach (px[i]) put_pixel(px[i], i == 0);
      stop_pixels();
      drain_codes();
   endtask

   // sizes below the minimum clamp up; second frame follows without frame_start
   task automatic test_clamped_sizes_and_wrap();
      logic [PIX_W-1:0] px [18] = '{255, 255, 255, 255, 0, 255, 255, 255, 255,
                                    0, 0, 0, 0, 255, 0, 0, 0, 0};
      write_reg(lbp_pkg::REG_IMAGE_WIDTH, 11'd0);
      write_reg(lbp_pkg::REG_IMAGE_HEIGHT, 11'd2);
      foreach (px[i]) put_pixel(px[i], i == 0);
      stop_pixels();
      drain_codes();
   endtask

   // long receiver hold while pixels keep coming, so the block backs up
   task automatic test_output_backpressure();
      write_reg(lbp_pkg::REG_IMAGE_WIDTH, 11'd8);
      write_reg(lbp_pkg::REG_IMAGE_HEIGHT, 11'd10);
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      rsp_hold_req  = HOLD_CYCLES;
      send_run(80, 1'b1, PIX_UNIFORM, 1'b0);
      stop_pixels();
      drain_codes();
   endtask

   // random geometry per phase; mostly whole frames, some run-on, cut and noisy
   task automatic test_random_frames();
      int unsigned           start_count, lim, w_eff, h_eff, rows, nframes, kind;
      logic [lbp_pkg::CSR_DATA_W-1:0] w_raw, h_raw;
      pixel_style_type       style;
      start_count = pixels_sent;
      while (pixels_sent - start_count < RANDOM_PIXELS) begin
         kind = $urandom_range(99);
         if (kind < 10) w_raw = lbp_pkg::CSR_DATA_W'($urandom_range(2));
         else if (kind < 80) w_raw = lbp_pkg::CSR_DATA_W'($urandom_range(12, 3));
         else w_raw = lbp_pkg::CSR_DATA_W'($urandom_range(40, 13));
         kind = $urandom_range(99);
         if (kind < 10) h_raw = lbp_pkg::CSR_DATA_W'($urandom_range(2));
         else if (kind < 85) h_raw = lbp_pkg::CSR_DATA_W'($urandom_range(8, 3));
         else h_raw = lbp_pkg::CSR_DATA_W'($urandom_range(2047, 1025));
         w_eff = size_clamp(w_raw);
         h_eff = size_clamp(h_raw);
         // going on without a frame start must only read line entries already
         // filled: the current column and every column of the new width
         lim = (pos_col >= w_eff) ? pos_col + 1 : w_eff;
         for (int unsigned k = 0; k < lim; k++)
            if (!line_up2_set[k]) need_sync = 1'b1;
         if ($urandom_range(3) != 0) need_sync = 1'b1;
         if ($urandom_range(1) != 0) begin
            write_reg(lbp_pkg::REG_IMAGE_WIDTH, w_raw);
            write_reg(lbp_pkg::REG_IMAGE_HEIGHT, h_raw);
         end else begin
            write_reg(lbp_pkg::REG_IMAGE_HEIGHT, h_raw);
            write_reg(lbp_pkg::REG_IMAGE_WIDTH, w_raw);
         end
         req_gaps_on   = ($urandom_range(3) != 0);
         rsp_stalls_on = ($urandom_range(3) != 0);
         nframes       = $urandom_range(4, 1);
         repeat (nframes) begin
            rows     = (h_eff > 8) ? $urandom_range(6, 3) : h_eff;
            style    = pixel_style_type'($urandom_range(2));
            tie_base = $urandom_range(253);
            kind     = $urandom_range(99);
            if (kind < 70) send_run(w_eff * rows, 1'b1, style, 1'b0);
            else if (kind < 80) send_run(w_eff * rows, 1'b0, style, 1'b0);
            else if (kind < 92) send_run($urandom_range(w_eff * rows - 1, 1), 1'b1, style, 1'b0);
            else send_run($urandom_range(2 * w_eff, 1), 1'b0, style, 1'b1);
         end
         stop_pixels();
         drain_codes();
      end
   endtask

   // receiver: random stalls, or a long hold when one is requested
   initial begin
      int unsigned stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            stall_left   = rsp_hold_req;
            rsp_hold_req = 0;
         end else if (stall_left == 0 && rsp_stalls_on && $urandom_range(99) < 20) begin
            stall_left = idle_len();
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // compare each code transfer with the oldest queued code
   always @(posedge clock) begin
      lbp_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_codes.size() == 0) begin
            report_mismatch("code with none pending", rsp_ch.code, 0);
         end else begin
            want = pending_codes.pop_front();
            if (rsp_ch.code !== want.code)
               report_mismatch("code", rsp_ch.code, want.code);
            if (rsp_ch.center_col !== want.center_col)
               report_mismatch("center_col", rsp_ch.center_col, want.center_col);
            if (rsp_ch.center_row !== want.center_row)
               report_mismatch("center_row", rsp_ch.center_row, want.center_row);
            if (rsp_ch.last !== want.last)
               report_mismatch("last", rsp_ch.last, want.last);
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_count = 0;
      else
         stall_count++;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.pixel       = '0;
      req_ch.frame_start = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = lbp_pkg::REG_IMAGE_WIDTH;
      csr_wdata          = '0;
      img_width          = lbp_pkg::WIDTH_RESET;
      img_height         = lbp_pkg::HEIGHT_RESET;
      pos_col            = 0;
      pos_row            = 0;
      mismatch_count     = 0;
      pixels_sent        = 0;
      stall_count        = 0;
      rsp_hold_req       = 0;
      tie_base           = 0;
      need_sync          = 1'b0;
      req_gaps_on        = 1'b0;
      rsp_stalls_on      = 1'b0;
      foreach (nbhd[i]) nbhd[i] = '0;
      foreach (line_up1[i]) begin
         line_up1[i]     = '0;
         line_up2[i]     = '0;
         line_up1_set[i] = 1'b0;
         line_up2_set[i] = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_smallest_frame();
      test_clamped_sizes_and_wrap();
      test_output_backpressure();
      test_random_frames();

      drain_codes();
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
